FILE: rtl/ifm_pkg.sv
// Shared types and constants for the inverter fault monitor.
// Used by ifm_cfg_regs, ifm_check and inverter_fault_monitor_unit; no dependencies.
package ifm_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 16;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_PROTECT_OFF        = 3'd0,
    REG_ADC_HIGH_LIMIT     = 3'd1,
    REG_ADC_LOW_LIMIT      = 3'd2,
    REG_OVER_CURRENT_LIMIT = 3'd3,
    REG_OVER_VOLT_LEVEL    = 3'd4,
    REG_UNDER_VOLT_LEVEL   = 3'd5
  } reg_index_t;

  // Fault codes.
  localparam logic [2:0] FC_NONE       = 3'd0;
  localparam logic [2:0] FC_OC_U       = 3'd1;
  localparam logic [2:0] FC_OC_V       = 3'd2;
  localparam logic [2:0] FC_OVER_VOLT  = 3'd3;
  localparam logic [2:0] FC_UNDER_VOLT = 3'd4;

  // Debounce counter limits.
  localparam logic [2:0] COUNT_TRIP_ABOVE = 3'd5;
  localparam logic [2:0] COUNT_HOLD       = 3'd6;

  // Register reset values.
  localparam logic [11:0] ADC_HIGH_RESET     = 12'd4000;
  localparam logic [11:0] ADC_LOW_RESET      = 12'd100;
  localparam logic [15:0] OC_LIMIT_RESET     = 16'd4800;
  localparam logic [15:0] OVER_VOLT_RESET    = 16'd6720;
  localparam logic [15:0] UNDER_VOLT_RESET   = 16'd3200;

  typedef struct packed {
    logic               kind;
    logic [11:0]        adc_current_a;
    logic [11:0]        adc_current_b;
    logic signed [15:0] phase_current_a;
    logic signed [15:0] phase_current_b;
    logic [15:0]        dc_voltage;
    logic               run_flag;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  fault_code;
    logic [15:0] fault_value;
    logic        tripped;
    logic        save_request;
  } out_word_t;

  typedef struct packed {
    logic        protect_off;
    logic [11:0] adc_high_limit;
    logic [11:0] adc_low_limit;
    logic [15:0] over_current_limit;
    logic [15:0] over_volt_level;
    logic [15:0] under_volt_level;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [15:0] value;
    logic [2:0]  ov_count_next;
    logic [2:0]  uv_count_next;
  } check_res_t;

endpackage

FILE: rtl/ifm_cfg_regs.sv
// Configuration register file of the inverter fault monitor.
// Depends on ifm_pkg for the register index codes and the cfg_t bundle.
module ifm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [ifm_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [ifm_pkg::CfgDataWidth-1:0]    cfg_data,
  output ifm_pkg::cfg_t                       cfg
);
  import ifm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protect_off        <= 1'b0;
      cfg.adc_high_limit     <= ADC_HIGH_RESET;
      cfg.adc_low_limit      <= ADC_LOW_RESET;
      cfg.over_current_limit <= OC_LIMIT_RESET;
      cfg.over_volt_level    <= OVER_VOLT_RESET;
      cfg.under_volt_level   <= UNDER_VOLT_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_PROTECT_OFF:        cfg.protect_off        <= cfg_data[0];
        REG_ADC_HIGH_LIMIT:     cfg.adc_high_limit     <= cfg_data[11:0];
        REG_ADC_LOW_LIMIT:      cfg.adc_low_limit      <= cfg_data[11:0];
        REG_OVER_CURRENT_LIMIT: cfg.over_current_limit <= cfg_data;
        REG_OVER_VOLT_LEVEL:    cfg.over_volt_level    <= cfg_data;
        REG_UNDER_VOLT_LEVEL:   cfg.under_volt_level   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/ifm_check.sv
// Trip evaluation for one check tick: current window and limit tests,
// voltage debounce counters. Purely combinational; depends on ifm_pkg.
module ifm_check (
  input  ifm_pkg::cfg_t       cfg,
  input  ifm_pkg::in_word_t   word,
  input  logic [2:0]          ov_count,
  input  logic [2:0]          uv_count,
  output ifm_pkg::check_res_t res
);
  import ifm_pkg::*;

  // Two's complement magnitude; the most negative value maps to 0x8000.
  function automatic logic [15:0] magnitude(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

  // Up/down count without the ceiling applied; a value above COUNT_TRIP_ABOVE means the counter tripped.
  function automatic logic [2:0] count_step(input logic [2:0] cnt, input logic cond);
    logic [2:0] n;
    if (cond) begin
      n = cnt + 3'd1;
    end else if (cnt != 3'd0) begin
      n = cnt - 3'd1;
    end else begin
      n = cnt;
    end
    return n;
  endfunction

  logic [15:0] mag_a;
  logic [15:0] mag_b;
  logic        adc_a_bad;
  logic        adc_b_bad;
  logic [2:0]  ov_step;
  logic [2:0]  uv_step;
  logic        ov_trip;
  logic        uv_trip;

  assign mag_a     = magnitude(word.phase_current_a);
  assign mag_b     = magnitude(word.phase_current_b);
  assign adc_a_bad = (word.adc_current_a > cfg.adc_high_limit) ||
                     (word.adc_current_a < cfg.adc_low_limit);
  assign adc_b_bad = (word.adc_current_b > cfg.adc_high_limit) ||
                     (word.adc_current_b < cfg.adc_low_limit);
  assign ov_step   = count_step(ov_count, word.dc_voltage > cfg.over_volt_level);
  assign uv_step   = count_step(uv_count, word.dc_voltage < cfg.under_volt_level);
  assign ov_trip   = ov_step > COUNT_TRIP_ABOVE;
  assign uv_trip   = uv_step > COUNT_TRIP_ABOVE;

  always_comb begin
    res.code          = FC_NONE;
    res.value         = 16'd0;
    res.ov_count_next = ov_count;
    res.uv_count_next = uv_count;
    if (!cfg.protect_off) begin
      if (word.kind) begin
        if (adc_a_bad) begin
          res.code  = FC_OC_U;
          res.value = {4'd0, word.adc_current_a};
        end else if (adc_b_bad) begin
          res.code  = FC_OC_V;
          res.value = {4'd0, word.adc_current_b};
        end else if (mag_a > cfg.over_current_limit) begin
          res.code  = FC_OC_U;
          res.value = mag_a;
        end else if (mag_b > cfg.over_current_limit) begin
          res.code  = FC_OC_V;
          res.value = mag_b;
        end
      end else begin
        // The under-voltage counter is frozen on a tick where over-voltage trips.
        if (ov_trip) begin
          res.ov_count_next = COUNT_HOLD;
          res.code          = FC_OVER_VOLT;
          res.value         = word.dc_voltage;
        end else begin
          res.ov_count_next = ov_step;
          res.uv_count_next = uv_trip ? COUNT_HOLD : uv_step;
          if (uv_trip) begin
            res.code  = FC_UNDER_VOLT;
            res.value = word.dc_voltage;
          end
        end
      end
    end
  end

endmodule

FILE: rtl/inverter_fault_monitor_unit.sv
// Top level of the inverter fault monitor: input register, trip evaluation,
// latched trip state and result register. Depends on ifm_pkg, ifm_cfg_regs, ifm_check.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   item     | item_valid, item_stall, item         | in
//   result   | result_valid, result_stall, result   | out
//   config   | cfg_write, cfg_index, cfg_data       | in
//
// One word is accepted per cycle while item_stall is low; it passes the input register, then the result register.
// The input register feeds the checks, and the counters and trip latch update
// as the word moves into the result register.
// A stalled result holds the result register; the input register then stalls too.
// Synchronous reset clears counters, trip latch, valids and loads register defaults.
module inverter_fault_monitor_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  ifm_pkg::in_word_t                   item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output ifm_pkg::out_word_t                  result,
  input  logic                                cfg_write,
  input  logic [ifm_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [ifm_pkg::CfgDataWidth-1:0]    cfg_data
);
  import ifm_pkg::*;

  cfg_t       cfg;
  check_res_t chk;

  in_word_t    stage_word;
  logic        stage_valid;
  logic        stage_move;
  logic        out_free;

  logic [2:0]  ov_count;
  logic [2:0]  uv_count;
  logic        trip_latched;
  logic        save_latched;
  logic        trip_latched_next;
  logic        save_latched_next;

  ifm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ifm_check u_check (
    .cfg      (cfg),
    .word     (stage_word),
    .ov_count (ov_count),
    .uv_count (uv_count),
    .res      (chk)
  );

  assign out_free   = !result_valid || !result_stall;
  assign stage_move = stage_valid && out_free;
  assign item_stall = stage_valid && !out_free;

  assign trip_latched_next = (chk.code != FC_NONE) ? 1'b1 : trip_latched;
  assign save_latched_next = (chk.code != FC_NONE) ? stage_word.run_flag : save_latched;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!item_stall) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_word <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      ov_count     <= 3'd0;
      uv_count     <= 3'd0;
      trip_latched <= 1'b0;
      save_latched <= 1'b0;
    end else begin
      if (out_free) begin
        result_valid <= stage_valid;
      end
      if (stage_move) begin
        ov_count     <= chk.ov_count_next;
        uv_count     <= chk.uv_count_next;
        trip_latched <= trip_latched_next;
        save_latched <= save_latched_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      result.fault_code   <= chk.code;
      result.fault_value  <= chk.value;
      result.tripped      <= trip_latched_next;
      result.save_request <= save_latched_next;
    end
  end

  a_fault_sets_trip: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.fault_code != FC_NONE) |-> result.tripped)
    else $error("shown fault without trip state");

  a_trip_sticky: assert property (@(posedge clk) disable iff (rst)
    trip_latched |=> trip_latched)
    else $error("trip latch cleared without reset");

  a_count_ceiling: assert property (@(posedge clk) disable iff (rst)
    (ov_count <= COUNT_HOLD) && (uv_count <= COUNT_HOLD))
    else $error("debounce counter past its ceiling");

  a_protect_off_quiet: assert property (@(posedge clk) disable iff (rst)
    stage_move && cfg.protect_off |=> result.fault_code == FC_NONE)
    else $error("trip reported while protection is off");

  a_protect_off_counts: assert property (@(posedge clk) disable iff (rst)
    stage_move && cfg.protect_off |=> $stable(ov_count) && $stable(uv_count))
    else $error("counters moved while protection is off");

endmodule
